// ===== hw/rtl/decc_pkg.sv =====
// Shared types and constants for the doorway entry and exit counter.
// Field widths, phase codes, register indexes and display colours.
// No dependencies.
`default_nettype none

package decc_pkg;

    localparam int LABEL_W  = 8;
    localparam int ROW_W    = 11;
    localparam int LINE_W   = 9;
    localparam int COLOUR_W = 24;
    localparam int TALLY_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int LABEL_CODES = 1 << LABEL_W;

    typedef logic [2:0] t_phase;

    localparam t_phase PH_ENTRY_ENTER = 3'd0;
    localparam t_phase PH_ENTRY_STAY  = 3'd1;
    localparam t_phase PH_ENTRY_LEFT  = 3'd2;
    localparam t_phase PH_EXIT_ENTER  = 3'd3;
    localparam t_phase PH_EXIT_STAY   = 3'd4;
    localparam t_phase PH_EXIT_LEFT   = 3'd5;
    localparam t_phase PH_ABSENT      = 3'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_STAY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_LEAVE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXIT_STAY   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXIT_LEAVE  = 2'd3;

    localparam logic [LINE_W-1:0] RST_ENTRY_STAY  = 9'd240;
    localparam logic [LINE_W-1:0] RST_ENTRY_LEAVE = 9'd90;
    localparam logic [LINE_W-1:0] RST_EXIT_STAY   = 9'd240;
    localparam logic [LINE_W-1:0] RST_EXIT_LEAVE  = 9'd400;

    localparam logic [COLOUR_W-1:0] COL_DEFAULT     = 24'h3054C9;
    localparam logic [COLOUR_W-1:0] COL_ENTRY_LEFT  = 24'h84CF34;
    localparam logic [COLOUR_W-1:0] COL_ENTRY_STAY  = 24'hCF8434;
    localparam logic [COLOUR_W-1:0] COL_EXIT_LEFT   = 24'hC93030;
    localparam logic [COLOUR_W-1:0] COL_EXIT_STAY   = 24'h347FCF;

    localparam logic [TALLY_W-1:0] TALLY_MAX = 16'hFFFF;

    // One label slot: phase, colour-known flag and colour.
    typedef struct packed {
        t_phase                phase;
        logic                  known;
        logic [COLOUR_W-1:0]   colour;
    } t_slot_word;

endpackage

`default_nettype wire

// ===== hw/rtl/decc_item_if.sv =====
// Valid/ready channels for sightings and results of the doorway counter.
// Depends on decc_pkg for field widths.
`default_nettype none

interface decc_item_if;
    logic                        valid;
    logic                        ready;
    logic [decc_pkg::LABEL_W-1:0] object_label;
    logic                        seen_before;
    logic [decc_pkg::ROW_W-1:0]  centre_row;

    modport source (output valid, output object_label, output seen_before,
                    output centre_row, input ready);
    modport sink   (input valid, input object_label, input seen_before,
                    input centre_row, output ready);
endinterface

interface decc_result_if;
    logic                          valid;
    logic                          ready;
    logic [decc_pkg::COLOUR_W-1:0] blob_colour;
    logic [decc_pkg::TALLY_W-1:0]  entries_total;
    logic [decc_pkg::TALLY_W-1:0]  exits_total;

    modport source (output valid, output blob_colour, output entries_total,
                    output exits_total, input ready);
    modport sink   (input valid, input blob_colour, input entries_total,
                    input exits_total, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/doorway_entry_exit_counter.sv =====
// Doorway entry and exit counter: top level.
// Depends on decc_pkg and the channel interfaces in decc_item_if.sv.
//
// One sighting is taken at a time: the accept edge registers the label's
// slot from the table memory, then the update state applies the tripwire
// rules and, once the result register is free or being drained, writes the
// slot back and loads the result register. Only then is the next sighting
// taken, so a stalled sink delays it. After reset the
// table is cleared slot by slot and no sighting is taken until it is done;
// configuration writes are taken at any time. Labels are folded into the
// table modulo LABEL_SLOTS. Both tallies saturate at 65535.
`default_nettype none

module doorway_entry_exit_counter #(
    parameter int LABEL_SLOTS = 256
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    decc_item_if.sink                               i_item,
    decc_result_if.source                           o_result,
    input  wire logic                               i_cfg_we,
    input  wire logic [decc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [decc_pkg::LINE_W-1:0]        i_cfg_data
);

    localparam int SW = (LABEL_SLOTS > 1) ? $clog2(LABEL_SLOTS) : 1;
    localparam logic [SW-1:0] LAST_SLOT = SW'(LABEL_SLOTS - 1);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    // Label to slot fold, a constant table.
    logic [SW-1:0] slot_lut [decc_pkg::LABEL_CODES];
    for (genvar g = 0; g < decc_pkg::LABEL_CODES; g++) begin : g_fold
        assign slot_lut[g] = SW'(g % LABEL_SLOTS);
    end

    decc_pkg::t_slot_word r_mem [LABEL_SLOTS];
    decc_pkg::t_slot_word r_rd_word;

    logic [1:0]                        r_state, n_state;
    logic [SW-1:0]                     r_clr_idx;
    logic [SW-1:0]                     r_slot;
    logic                              r_tracked;
    logic [decc_pkg::ROW_W-1:0]        r_row;
    logic [decc_pkg::LINE_W-1:0]       r_es_line, r_el_line, r_xs_line, r_xl_line;
    logic [decc_pkg::TALLY_W-1:0]      r_entry_tally, n_entry_tally;
    logic [decc_pkg::TALLY_W-1:0]      r_exit_tally, n_exit_tally;
    logic                              r_out_valid;
    logic [decc_pkg::COLOUR_W-1:0]     r_out_colour;

    logic                              in_accept;
    logic                              can_load;
    logic                              do_update;
    logic [SW-1:0]                     rd_slot;
    decc_pkg::t_slot_word              n_word;
    decc_pkg::t_slot_word              clr_word;
    logic                              mem_we;
    logic [SW-1:0]                     mem_waddr;
    decc_pkg::t_slot_word              mem_wdata;
    logic [decc_pkg::ROW_W-1:0]        es, el, xs, xl;

    assign i_item.ready = (r_state == ST_IDLE);
    assign in_accept    = i_item.valid && i_item.ready;
    assign rd_slot      = slot_lut[i_item.object_label];
    assign can_load     = !r_out_valid || o_result.ready;
    assign do_update    = (r_state == ST_UPDATE) && can_load;

    assign o_result.valid         = r_out_valid;
    assign o_result.blob_colour   = r_out_colour;
    assign o_result.entries_total = r_entry_tally;
    assign o_result.exits_total   = r_exit_tally;

    // Lines are whole pixels, rows quarter pixels.
    assign es = {r_es_line, 2'b00};
    assign el = {r_el_line, 2'b00};
    assign xs = {r_xs_line, 2'b00};
    assign xl = {r_xl_line, 2'b00};

    always_comb begin
        n_word        = r_rd_word;
        n_entry_tally = r_entry_tally;
        n_exit_tally  = r_exit_tally;
        if (r_tracked) begin
            case (r_rd_word.phase)
                decc_pkg::PH_ENTRY_ENTER: begin
                    if (r_row < es && r_row > el) begin
                        n_word.phase = decc_pkg::PH_ENTRY_STAY;
                    end
                end
                decc_pkg::PH_ENTRY_STAY: begin
                    n_word.known = 1'b1;
                    if (r_row < el) begin
                        n_word.phase  = decc_pkg::PH_ENTRY_LEFT;
                        n_word.colour = decc_pkg::COL_ENTRY_LEFT;
                    end else begin
                        n_word.colour = decc_pkg::COL_ENTRY_STAY;
                    end
                end
                decc_pkg::PH_ENTRY_LEFT: begin
                    n_word.phase = decc_pkg::PH_ABSENT;
                    if (r_entry_tally != decc_pkg::TALLY_MAX) begin
                        n_entry_tally = r_entry_tally + 1'b1;
                    end
                end
                decc_pkg::PH_EXIT_ENTER: begin
                    if (r_row > xs && r_row < xl) begin
                        n_word.phase = decc_pkg::PH_EXIT_STAY;
                    end
                end
                decc_pkg::PH_EXIT_STAY: begin
                    n_word.known = 1'b1;
                    if (r_row > xl) begin
                        n_word.phase  = decc_pkg::PH_EXIT_LEFT;
                        n_word.colour = decc_pkg::COL_EXIT_LEFT;
                    end else begin
                        n_word.colour = decc_pkg::COL_EXIT_STAY;
                    end
                end
                decc_pkg::PH_EXIT_LEFT: begin
                    n_word.phase = decc_pkg::PH_ABSENT;
                    if (r_exit_tally != decc_pkg::TALLY_MAX) begin
                        n_exit_tally = r_exit_tally + 1'b1;
                    end
                end
                decc_pkg::PH_ABSENT: begin
                    n_word.phase = (r_row > es) ? decc_pkg::PH_ENTRY_ENTER
                                                : decc_pkg::PH_EXIT_ENTER;
                    if (!r_rd_word.known) begin
                        n_word.known  = 1'b1;
                        n_word.colour = decc_pkg::COL_DEFAULT;
                    end
                end
                default: begin
                end
            endcase
        end
        // A slot still unknown after the rules is marked known with colour zero.
        if (!n_word.known) begin
            n_word.known  = 1'b1;
            n_word.colour = '0;
        end
    end

    always_comb begin
        clr_word.phase  = decc_pkg::PH_ABSENT;
        clr_word.known  = (r_clr_idx == '0);
        clr_word.colour = (r_clr_idx == '0) ? decc_pkg::COL_DEFAULT : '0;
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_slot;
        mem_wdata = n_word;
        if (r_state == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_idx;
            mem_wdata = clr_word;
        end else if (do_update) begin
            mem_we = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_idx == LAST_SLOT) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (can_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Table memory: one write, one registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (in_accept) begin
            r_rd_word <= r_mem[rd_slot];
        end
    end

    // Sighting and result payload.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_slot    <= rd_slot;
            r_tracked <= i_item.seen_before;
            r_row     <= i_item.centre_row;
        end
        if (do_update) begin
            r_out_colour <= n_word.colour;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_clr_idx     <= '0;
            r_entry_tally <= '0;
            r_exit_tally  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (do_update) begin
                r_entry_tally <= n_entry_tally;
                r_exit_tally  <= n_exit_tally;
                r_out_valid   <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_es_line <= decc_pkg::RST_ENTRY_STAY;
            r_el_line <= decc_pkg::RST_ENTRY_LEAVE;
            r_xs_line <= decc_pkg::RST_EXIT_STAY;
            r_xl_line <= decc_pkg::RST_EXIT_LEAVE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                decc_pkg::CFG_ENTRY_STAY:  r_es_line <= i_cfg_data;
                decc_pkg::CFG_ENTRY_LEAVE: r_el_line <= i_cfg_data;
                decc_pkg::CFG_EXIT_STAY:   r_xs_line <= i_cfg_data;
                decc_pkg::CFG_EXIT_LEAVE:  r_xl_line <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/decc_checker.sv =====
// Port-level checks for the doorway entry and exit counter, and their bind.
// Depends on decc_pkg; attaches to doorway_entry_exit_counter.
`default_nettype none

module decc_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_in_valid,
    input wire logic                              i_in_ready,
    input wire logic                              i_out_valid,
    input wire logic                              i_out_ready,
    input wire logic [decc_pkg::COLOUR_W-1:0]     i_out_colour,
    input wire logic [decc_pkg::TALLY_W-1:0]      i_out_entries,
    input wire logic [decc_pkg::TALLY_W-1:0]      i_out_exits
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_colour) && $stable(i_out_entries)
            && $stable(i_out_exits))
        else $error("stalled result changed");

    // One item in flight: no accept right after an accept.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("item taken while previous item in flight");

    // Tallies only step up by one.
    a_entries_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$stable(i_out_entries) |->
            i_out_entries == $past(i_out_entries) + 16'd1)
        else $error("entry tally jumped");

    a_exits_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$stable(i_out_exits) |->
            i_out_exits == $past(i_out_exits) + 16'd1)
        else $error("exit tally jumped");

endmodule

bind doorway_entry_exit_counter decc_checker u_decc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_item.valid),
    .i_in_ready    (i_item.ready),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_out_colour  (o_result.blob_colour),
    .i_out_entries (o_result.entries_total),
    .i_out_exits   (o_result.exits_total)
);

`default_nettype wire
